// ----- rtl/eehr_pkg.sv -----
// ----------------------------------------------------------------------------
// eehr_pkg - shared types and constants for the encoder event history ring
// Entry layout, request codes, chain control and derived widths.
// ----------------------------------------------------------------------------
package eehr_pkg;

	// number of cells in the history chain
	localparam int HISTORY_DEPTH = 32;
	// most entries one dump may emit
	localparam int RESULT_LIMIT  = 32;

	// width of the valid count (holds 0..HISTORY_DEPTH)
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	// width of the rotation counter (holds 0..HISTORY_DEPTH-1)
	localparam int ROT_W = $clog2(HISTORY_DEPTH);
	// width of the dump limit field and emitted count
	localparam int LIM_W = 6;
	// common width for comparing counts against the dump limit
	localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

	// request codes
	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_DUMP  = 2'd2;

	// one stored encoder event
	typedef struct packed {
		logic [31:0]       stamp;
		logic signed [1:0] dir;
		logic [7:0]        drive;
	} entry_t;

	// control sent to every cell of the chain
	typedef struct packed {
		logic shift;   // push a new entry in at cell 0, all move one older
		logic rotate;  // move every entry one place toward cell 0, cell 0 wraps
	} chain_ctl_t;

endpackage

// ----- rtl/eehr_cell.sv -----
// ----------------------------------------------------------------------------
// eehr_cell - one cell of the history chain
// Holds one entry; takes the newer neighbor on a push and the older
// neighbor on a rotation.
// ----------------------------------------------------------------------------
module eehr_cell (
	input  logic                 clk,
	input  eehr_pkg::chain_ctl_t ctl,
	input  eehr_pkg::entry_t     newer,
	input  eehr_pkg::entry_t     older,
	output eehr_pkg::entry_t     entry
);

	eehr_pkg::entry_t entry_q;

	// load from a neighbor, otherwise hold
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= newer;
		end else if (ctl.rotate) begin
			entry_q <= older;
		end
	end

	assign entry = entry_q;

endmodule

// ----- rtl/encoder_event_history_ring.sv -----
// ----------------------------------------------------------------------------
// encoder_event_history_ring - history of encoder events with position sum
// A chain of cells holds the events, newest in cell 0. Add pushes an event
// in and updates the position sum; clear empties the history; dump walks
// the chain by rotation and emits the entries newest first.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata                                  tuser        tlast
//  s_axis    in         time, direction, drive, max_entries    func         -
//  m_axis    out        sum, latest, entry time/dir/drive,     entry_valid  last
//                       emitted_count
//
//  Add, clear, unused codes and a dump with nothing to emit give one status
//  request each.
//  A dump with entries rotates the whole chain once, one place per step, the
//  first min(max_entries, count, 32) steps emitting one request each.
//  The input is not ready while a dump is rotating or the output is stalled.
//  Output stalls hold the rotation while it emits; the output register parts
//  the two sides.
//  Reset clears counts, sum and handshake state; the cells are not reset.
//
module encoder_event_history_ring (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [31:0] event_time, [33:32] direction, [41:34] drive_level,
	// [47:42] max_entries
	input  logic [47:0]   s_axis_tdata,
	// [1:0] func
	input  logic [1:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [31:0] position_sum, [63:32] latest_time, [95:64] entry_time,
	// [97:96] entry_direction, [105:98] entry_drive, [111:106] emitted_count
	output logic [111:0]  m_axis_tdata,
	// [0] entry_valid
	output logic          m_axis_tuser,
	output logic          m_axis_tlast
);

	localparam int D = eehr_pkg::HISTORY_DEPTH;

	// input fields
	logic [1:0]                  func;
	eehr_pkg::entry_t            new_entry;
	logic [eehr_pkg::LIM_W-1:0]  max_entries;

	assign func            = s_axis_tuser;
	assign new_entry.stamp = s_axis_tdata[31:0];
	assign new_entry.dir   = s_axis_tdata[33:32];
	assign new_entry.drive = s_axis_tdata[41:34];
	assign max_entries     = s_axis_tdata[47:42];

	// control state
	logic [31:0]                 acc_q;
	logic [eehr_pkg::CNT_W-1:0]  count_q;
	logic [31:0]                 latest_q;
	logic                        busy_q;
	logic [eehr_pkg::ROT_W-1:0]  rot_q;
	logic [eehr_pkg::LIM_W-1:0]  lim_q;

	// output register
	logic          out_valid_q;
	logic [31:0]   out_sum_q;
	logic [31:0]   out_latest_q;
	logic          out_evalid_q;
	logic [31:0]   out_etime_q;
	logic [1:0]    out_edir_q;
	logic [7:0]    out_edrive_q;
	logic [5:0]    out_ecount_q;
	logic          out_last_q;

	eehr_pkg::chain_ctl_t ctl;
	eehr_pkg::entry_t     cells [D];

	logic                        slot_free;
	logic                        in_acc;
	logic                        emitting;
	logic                        step;
	logic                        load_out;
	logic [31:0]                 dir_ext;
	logic [31:0]                 acc_add;
	logic [31:0]                 latest_now;
	logic [eehr_pkg::CMP_W-1:0]  lim_a;
	logic [eehr_pkg::CMP_W-1:0]  lim_b;
	logic [eehr_pkg::CMP_W-1:0]  lim_n;

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !busy_q && slot_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// emit while the rotation count is below the dump limit
	assign emitting = eehr_pkg::CMP_W'(rot_q) < eehr_pkg::CMP_W'(lim_q);
	assign step     = busy_q && (!emitting || slot_free);

	// a new result loads for every request but a dump with entries, and per emission
	assign load_out = (in_acc && !(func == eehr_pkg::FUNC_DUMP && lim_n != '0)) ||
		(step && emitting);

	assign dir_ext    = {{30{new_entry.dir[1]}}, new_entry.dir};
	assign acc_add    = acc_q + dir_ext;
	assign latest_now = (count_q != '0) ? latest_q : 32'd0;

	// dump limit: smaller of max_entries, count and the result limit
	always_comb begin
		lim_a = (eehr_pkg::CMP_W'(max_entries) < eehr_pkg::CMP_W'(count_q)) ?
			eehr_pkg::CMP_W'(max_entries) : eehr_pkg::CMP_W'(count_q);
		lim_b = eehr_pkg::CMP_W'(eehr_pkg::RESULT_LIMIT);
		lim_n = (lim_a < lim_b) ? lim_a : lim_b;
	end

	// chain control
	always_comb begin
		ctl.shift  = in_acc && (func == eehr_pkg::FUNC_ADD);
		ctl.rotate = step;
	end

	// chain of cells: cell 0 newest, rotation wraps cell 0 to the far end
	for (genvar i = 0; i < D; i++) begin : g_cell
		if (i == 0) begin : g_head
			eehr_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.newer (new_entry),
				.older (cells[1]),
				.entry (cells[0])
			);
		end else if (i == D - 1) begin : g_tail
			eehr_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.newer (cells[i-1]),
				.older (cells[0]),
				.entry (cells[i])
			);
		end else begin : g_mid
			eehr_cell u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.newer (cells[i-1]),
				.older (cells[i+1]),
				.entry (cells[i])
			);
		end
	end

	// request handling and dump sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			rot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				case (func)
					eehr_pkg::FUNC_ADD: begin
						acc_q <= acc_add;
						if (count_q != eehr_pkg::CNT_W'(D)) begin
							count_q <= count_q + 1'b1;
						end
					end
					eehr_pkg::FUNC_CLEAR: begin
						acc_q   <= '0;
						count_q <= '0;
					end
					eehr_pkg::FUNC_DUMP: begin
						if (lim_n != '0) begin
							busy_q <= 1'b1;
							rot_q  <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			// advance the rotation; finish after one full turn
			if (step) begin
				if (rot_q == eehr_pkg::ROT_W'(D - 1)) begin
					busy_q <= 1'b0;
				end else begin
					rot_q <= rot_q + 1'b1;
				end
			end
			// load a new result, otherwise drop a taken one
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: latest stamp, dump limit and output fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (func == eehr_pkg::FUNC_ADD) begin
				latest_q <= new_entry.stamp;
			end
			if (func == eehr_pkg::FUNC_DUMP) begin
				lim_q <= eehr_pkg::LIM_W'(lim_n);
			end
			// status request for every code but a dump with entries
			out_evalid_q <= 1'b0;
			out_etime_q  <= '0;
			out_edir_q   <= '0;
			out_edrive_q <= '0;
			out_ecount_q <= '0;
			out_last_q   <= 1'b1;
			case (func)
				eehr_pkg::FUNC_ADD: begin
					out_sum_q    <= acc_add;
					out_latest_q <= new_entry.stamp;
				end
				eehr_pkg::FUNC_CLEAR: begin
					out_sum_q    <= '0;
					out_latest_q <= '0;
				end
				default: begin
					out_sum_q    <= acc_q;
					out_latest_q <= latest_now;
				end
			endcase
		end else if (step && emitting) begin
			out_sum_q    <= acc_q;
			out_latest_q <= latest_now;
			out_evalid_q <= 1'b1;
			out_etime_q  <= cells[0].stamp;
			out_edir_q   <= cells[0].dir;
			out_edrive_q <= cells[0].drive;
			out_ecount_q <= 6'(rot_q) + 6'd1;
			out_last_q   <= (eehr_pkg::LIM_W'(rot_q) + 1'b1) == lim_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_ecount_q, out_edrive_q, out_edir_q, out_etime_q,
		out_latest_q, out_sum_q};
	assign m_axis_tuser  = out_evalid_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the encoder event history ring
// Sends add, clear and dump requests through the input stream and predicts
// every output request: position sum, latest timestamp and the history
// walked newest first. Random gaps on both sides, one long output hold
// and drain pauses on the input side.
// ----------------------------------------------------------------------------
module tb_top;

	// unused request code, answered with a status request
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	// step direction patterns; the odd pattern counts as minus two
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_ODD  = 2'b10;
	localparam logic [1:0] DIR_REV  = 2'b11;

	localparam int DEPTH         = eehr_pkg::HISTORY_DEPTH;
	localparam int RANDOM_ITEMS  = 420;
	localparam int HOLD_AT       = 60;
	localparam int HOLD_CYCLES   = 160;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = DEPTH + 16;

	// one output request as the block should present it
	typedef struct {
		logic [31:0] sum;
		logic [31:0] latest;
		logic        entry_valid;
		logic [31:0] etime;
		logic [1:0]  edir;
		logic [7:0]  edrive;
		logic [5:0]  count;
		logic        last;
	} history_result_t;

	// ------------------------------------------------------------------------
	// history predictor and result checker
	// ------------------------------------------------------------------------
	class history_scoreboard;
		eehr_pkg::entry_t ring[DEPTH];
		int              wr_ptr;
		int              fill;
		logic [31:0]     pos_sum;
		history_result_t pending_q[$];
		int              errors;
		int              n_add, n_clear, n_dump, n_spare, n_results;
		int              n_overwrite, n_deepest;

		function new();
			wr_ptr    = 0;
			fill      = 0;
			pos_sum   = '0;
			errors    = 0;
			n_add     = 0;
			n_clear   = 0;
			n_dump    = 0;
			n_spare   = 0;
			n_results = 0;
			n_overwrite = 0;
			n_deepest = 0;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function logic [31:0] newest_stamp();
			if (fill == 0)
				return '0;
			return ring[(wr_ptr + DEPTH - 1) % DEPTH].stamp;
		endfunction

		function void push_status();
			history_result_t r;
			r.sum         = pos_sum;
			r.latest      = newest_stamp();
			r.entry_valid = 1'b0;
			r.etime       = '0;
			r.edir        = '0;
			r.edrive      = '0;
			r.count       = '0;
			r.last        = 1'b1;
			pending_q.push_back(r);
		endfunction

		// update the history for one accepted request, queue what it yields
		function void note_request(logic [1:0] func, logic [47:0] data);
			logic [1:0]      dir;
			int              lim;
			int              idx;
			history_result_t r;
			dir = data[33:32];
			lim = int'(data[47:42]);
			case (func)
				eehr_pkg::FUNC_ADD: begin
					ring[wr_ptr].stamp = data[31:0];
					ring[wr_ptr].dir   = dir;
					ring[wr_ptr].drive = data[41:34];
					wr_ptr = (wr_ptr + 1) % DEPTH;
					if (fill < DEPTH)
						fill++;
					else
						n_overwrite++;
					pos_sum = pos_sum + {{30{dir[1]}}, dir};
					n_add++;
					push_status();
				end
				eehr_pkg::FUNC_CLEAR: begin
					// write pointer stays where it is
					fill    = 0;
					pos_sum = '0;
					n_clear++;
					push_status();
				end
				eehr_pkg::FUNC_DUMP: begin
					n_dump++;
					if (lim > fill)
						lim = fill;
					if (lim > eehr_pkg::RESULT_LIMIT)
						lim = eehr_pkg::RESULT_LIMIT;
					if (lim > n_deepest)
						n_deepest = lim;
					if (lim == 0)
						push_status();
					for (int k = 0; k < lim; k++) begin
						idx = (wr_ptr + DEPTH - 1 - k) % DEPTH;
						r.sum         = pos_sum;
						r.latest      = newest_stamp();
						r.entry_valid = 1'b1;
						r.etime       = ring[idx].stamp;
						r.edir        = ring[idx].dir;
						r.edrive      = ring[idx].drive;
						r.count       = 6'(k + 1);
						r.last        = (k + 1 == lim);
						pending_q.push_back(r);
					end
				end
				default: begin
					n_spare++;
					push_status();
				end
			endcase
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		// compare one accepted output request with the oldest expectation
		function void check_result(logic [111:0] data, logic valid_flag, logic last_flag);
			history_result_t r;
			n_results++;
			if (pending_q.size() == 0) begin
				$error("output request 0x%0h arrived with nothing expected", data);
				errors++;
				return;
			end
			r = pending_q.pop_front();
			compare_field("position_sum", r.sum, data[31:0]);
			compare_field("latest_time", r.latest, data[63:32]);
			compare_field("entry_valid", 32'(r.entry_valid), 32'(valid_flag));
			compare_field("entry_time", r.etime, data[95:64]);
			compare_field("entry_direction", 32'(r.edir), 32'(data[97:96]));
			compare_field("entry_drive", 32'(r.edrive), 32'(data[105:98]));
			compare_field("emitted_count", 32'(r.count), 32'(data[111:106]));
			compare_field("last", 32'(r.last), 32'(last_flag));
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic [47:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tready = 1'b0;
	logic         s_axis_tready;
	logic         m_axis_tvalid;
	logic [111:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	history_scoreboard sb = new();
	int                sender_quiet = 0;
	int                sink_quiet = 0;
	int                results_taken = 0;
	int                idle_cycles = 0;

	encoder_event_history_ring i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// end the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// random idle gap, with occasional stretches of back-to-back traffic
	function automatic int draw_gap(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			quiet = $urandom_range(15, 40);
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	// offer one request and hold it until accepted
	task automatic send_request(logic [1:0] func, logic [31:0] etime, logic [1:0] dir,
	                            logic [7:0] drive, logic [5:0] lim);
		int gap;
		gap = draw_gap(sender_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {lim, drive, dir, etime};
		s_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(func, {lim, drive, dir, etime});
	endtask

	// stop offering and wait for every expected output request
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [1:0] draw_dir();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return DIR_ODD;
		case (r % 3)
			0: return DIR_NONE;
			1: return DIR_FWD;
			default: return DIR_REV;
		endcase
	endfunction

	function automatic logic [5:0] draw_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 6'(eehr_pkg::RESULT_LIMIT);
		if (r < 3)
			return 6'($urandom_range(34, 63));
		return 6'($urandom_range(0, 33));
	endfunction

	// output side: random stalls, one long hold, check every request taken
	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (results_taken == HOLD_AT)
				gap = HOLD_CYCLES;
			else
				gap = draw_gap(sink_quiet);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			results_taken++;
		end
	end

	initial begin : request_source
		int  n_random;
		int  seg;
		int  r;
		bit  paused;
		n_random = 0;
		paused   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// dump and spare code on an empty history
		send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom), 6'd32);
		send_request(FUNC_SPARE, $urandom, draw_dir(), 8'($urandom), 6'($urandom));
		// field extremes and every direction pattern
		send_request(eehr_pkg::FUNC_ADD, 32'h0, DIR_NONE, 8'h00, 6'd0);
		send_request(eehr_pkg::FUNC_ADD, 32'hFFFF_FFFF, DIR_FWD, 8'hFF, 6'd63);
		send_request(eehr_pkg::FUNC_ADD, $urandom, DIR_REV, 8'h5A, 6'd1);
		send_request(eehr_pkg::FUNC_ADD, $urandom, DIR_ODD, 8'hA5, 6'd32);
		// dump limits: zero, one, two, and one above both the count and the cap
		send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom), 6'd0);
		send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom), 6'd1);
		send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom), 6'd2);
		send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom), 6'd63);
		send_request(FUNC_SPARE, $urandom, draw_dir(), 8'($urandom), 6'd5);
		// clear keeps the write pointer; history reads back empty
		send_request(eehr_pkg::FUNC_CLEAR, $urandom, draw_dir(), 8'($urandom),
		             6'($urandom));
		send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom), 6'd32);
		send_request(eehr_pkg::FUNC_ADD, 32'h8000_0000, DIR_ODD, 8'h80, 6'd0);
		send_request(eehr_pkg::FUNC_ADD, 32'h7FFF_FFFF, DIR_REV, 8'h7F, 6'd63);
		send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom), 6'd63);
		send_request(eehr_pkg::FUNC_CLEAR, $urandom, draw_dir(), 8'($urandom),
		             6'($urandom));
		drain();

		// segments of adds, dumps and spare codes, long ones wrap the ring, mostly closed by a clear
		while (n_random < RANDOM_ITEMS) begin
			seg = $urandom_range(8, 72);
			for (int i = 0; i < seg && n_random < RANDOM_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					send_request(eehr_pkg::FUNC_ADD, $urandom, draw_dir(), 8'($urandom),
					             6'($urandom));
				else if (r < 96)
					send_request(eehr_pkg::FUNC_DUMP, $urandom, draw_dir(), 8'($urandom),
					             draw_limit());
				else
					send_request(FUNC_SPARE, $urandom, draw_dir(), 8'($urandom),
					             6'($urandom));
				n_random++;
			end
			if ($urandom_range(0, 3) != 0) begin
				send_request(eehr_pkg::FUNC_CLEAR, $urandom, draw_dir(), 8'($urandom),
				             6'($urandom));
				n_random++;
			end
			if (!paused && n_random >= RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("requests: %0d add, %0d clear, %0d dump, %0d spare; %0d results checked",
		         sb.n_add, sb.n_clear, sb.n_dump, sb.n_spare, sb.n_results);
		$display("ring overwrites: %0d, deepest dump: %0d entries",
		         sb.n_overwrite, sb.n_deepest);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
